// ===== src/mfpc_pkg.sv =====
`default_nettype none

package mfpc_pkg;

    localparam int SAMPLE_W = 10;
    localparam int CTRL_W   = 7;
    localparam int VAL_W    = 7;
    localparam int TIME_W   = 32;
    localparam int DEB_W    = 8;
    localparam int HOLD_W   = 16;
    localparam int CHAN_W   = 5;
    localparam int LED_W    = 7;

    localparam int STORE_DEPTH = 128;

    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    // input item layout
    localparam int S_SAMPLE_LSB = 0;
    localparam int S_UP_BIT     = 10;
    localparam int S_DOWN_BIT   = 11;
    localparam int S_TIME_LSB   = 12;

    // result item tdata layout
    localparam int M_NUM_LSB   = 0;
    localparam int M_VAL_LSB   = 7;
    localparam int M_CHAN_LSB  = 14;
    localparam int M_LED_LSB   = 19;
    localparam int M_USED_W    = 26;

    // result item tuser layout
    localparam int M_SEND_BIT  = 0;
    localparam int M_METER_BIT = 1;

    localparam logic [SAMPLE_W-1:0] DEADBAND_RESET = 10'd8;
    localparam logic [DEB_W-1:0]    DEBOUNCE_RESET = 8'd30;
    localparam logic [HOLD_W-1:0]   HOLDOFF_RESET  = 16'd500;
    localparam logic [CHAN_W-1:0]   CHANNEL_RESET  = 5'd1;

    localparam logic [VAL_W-1:0]  VALUE_RESET = 7'd64;
    localparam logic [CTRL_W-1:0] CTRL_RESET  = 7'd20;
    localparam int METER_STEP  = 18;
    localparam int SCALE_SHIFT = 3;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DEADBAND = 2'd0,
        CFG_DEBOUNCE = 2'd1,
        CFG_HOLDOFF  = 2'd2,
        CFG_CHANNEL  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic [CTRL_W-1:0]   ctrl_before;
        logic [CTRL_W-1:0]   ctrl_after;
        logic                stepped;
        logic                meter;
        logic                fwd_a;
        logic                fwd_b;
        logic [VAL_W-1:0]    fwd_data;
        logic                vld_a;
        logic                vld_b;
    } stage_t;

    function automatic logic [LED_W-1:0] meter_bar(input logic [VAL_W-1:0] v);
        logic [LED_W-1:0] bar;
        bar = '0;
        for (int i = 0; i < LED_W; i++) begin
            bar[i] = (v > VAL_W'(i * METER_STEP));
        end
        return bar;
    endfunction

endpackage

`default_nettype wire

// ===== src/mfpc_ram.sv =====
`default_nettype none

module mfpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr_a,
    input  wire logic [AW-1:0]    raddr_b,
    output logic      [WIDTH-1:0] rdata_a,
    output logic      [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

`default_nettype wire

// ===== src/midi_fader_pickup_controller.sv =====
// Fader pickup controller for a one-fader control surface.
// s_ channel: one scan pass per item (fader sample, up/down button levels,
// millisecond timestamp). m_ channel: exactly one result item per scan pass,
// carrying controller number and value, channel and LED pattern on m_tdata,
// and the control change flag and display mode on m_tuser.
// Configuration: cfg_wr_en/cfg_addr/cfg_wr_data write deadband, debounce,
// toggle hold-off and channel; write only while no item is in flight.
// Pipeline: two register stages (value store read, output register); a result
// item passes through both before it is presented on the m_ channel.
// Throughput: one item per cycle while m_tready is high. The value store is a
// 128 x 7 memory with two read ports and one write port; the write of one pass is
// forwarded to the reads of the next so passes overlap without a bubble.
// Reset: aresetn (synchronous, low) clears all control state at once; a
// per-entry valid flag makes every store entry read as 64 until written, so
// no clearing pass is needed and the block takes items right after reset.
// Receiver stall: the output register holds its item, one more item waits
// in the compute stage, and s_tready then drops until m_tready returns.
`default_nettype none

module midi_fader_pickup_controller (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // fader_sample[9:0], up_pressed[10], down_pressed[11], time_ms[43:12]
    input  wire logic [mfpc_pkg::S_TDATA_W-1:0]    s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // controller_number[6:0], controller_value[13:7], channel_out[18:14],
    // led_pattern[25:19]
    output logic      [mfpc_pkg::M_TDATA_W-1:0]    m_tdata,
    // send_change[0], display_is_meter[1]
    output logic      [mfpc_pkg::M_TUSER_W-1:0]    m_tuser,
    input  wire logic                              cfg_wr_en,
    input  wire logic [mfpc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [mfpc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int SW = mfpc_pkg::SAMPLE_W;
    localparam int CW = mfpc_pkg::CTRL_W;
    localparam int VW = mfpc_pkg::VAL_W;
    localparam int TW = mfpc_pkg::TIME_W;

    // configuration
    logic [SW-1:0]                 deadband_reg;
    logic [mfpc_pkg::DEB_W-1:0]    debounce_reg;
    logic [mfpc_pkg::HOLD_W-1:0]   holdoff_reg;
    logic [mfpc_pkg::CHAN_W-1:0]   channel_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadband_reg <= mfpc_pkg::DEADBAND_RESET;
            debounce_reg <= mfpc_pkg::DEBOUNCE_RESET;
            holdoff_reg  <= mfpc_pkg::HOLDOFF_RESET;
            channel_reg  <= mfpc_pkg::CHANNEL_RESET;
        end else if (cfg_wr_en) begin
            unique case (mfpc_pkg::cfg_idx_t'(cfg_addr))
                mfpc_pkg::CFG_DEADBAND: deadband_reg <= cfg_wr_data[SW-1:0];
                mfpc_pkg::CFG_DEBOUNCE: debounce_reg <= cfg_wr_data[mfpc_pkg::DEB_W-1:0];
                mfpc_pkg::CFG_HOLDOFF:  holdoff_reg  <= cfg_wr_data[mfpc_pkg::HOLD_W-1:0];
                mfpc_pkg::CFG_CHANNEL:  channel_reg  <= cfg_wr_data[mfpc_pkg::CHAN_W-1:0];
                default: ;
            endcase
        end
    end

    // input fields
    logic [SW-1:0] in_sample;
    logic          in_up;
    logic          in_down;
    logic [TW-1:0] in_time;

    assign in_sample = s_tdata[mfpc_pkg::S_SAMPLE_LSB +: SW];
    assign in_up     = s_tdata[mfpc_pkg::S_UP_BIT];
    assign in_down   = s_tdata[mfpc_pkg::S_DOWN_BIT];
    assign in_time   = s_tdata[mfpc_pkg::S_TIME_LSB +: TW];

    // button and display state
    logic [CW-1:0] active_reg,       active_next;
    logic          up_last_reg,      up_last_next;
    logic          down_last_reg,    down_last_next;
    logic [TW-1:0] up_edge_reg,      up_edge_next;
    logic [TW-1:0] down_edge_reg,    down_edge_next;
    logic [TW-1:0] toggle_time_reg,  toggle_time_next;
    logic          toggle_hold_reg,  toggle_hold_next;
    logic          meter_reg,        meter_next;
    logic          stepped;

    logic          s_accept;
    logic          s1_fire;
    logic          s1_wr;
    logic          s1_valid_reg;
    mfpc_pkg::stage_t s1_reg;

    logic [TW-1:0] el_toggle;
    logic [TW-1:0] el_up;
    logic [TW-1:0] el_down;
    logic          both;
    logic          up_step;

    assign el_toggle = in_time - toggle_time_reg;
    assign el_up     = in_time - up_edge_reg;
    assign el_down   = in_time - down_edge_reg;
    assign both      = in_up && in_down;

    always_comb begin
        active_next      = active_reg;
        up_last_next     = up_last_reg;
        down_last_next   = down_last_reg;
        up_edge_next     = up_edge_reg;
        down_edge_next   = down_edge_reg;
        toggle_time_next = toggle_time_reg;
        toggle_hold_next = toggle_hold_reg;
        meter_next       = meter_reg;
        stepped          = 1'b0;
        up_step          = 1'b0;
        if (both && !toggle_hold_reg) begin
            toggle_hold_next = 1'b1;
            toggle_time_next = in_time;
            meter_next       = !meter_reg;
        end else begin
            if (!both && el_toggle > TW'(holdoff_reg)) begin
                toggle_hold_next = 1'b0;
            end
            if (in_up != up_last_reg && el_up > TW'(debounce_reg)) begin
                up_last_next = in_up;
                up_edge_next = in_time;
                if (in_up) begin
                    active_next = active_reg + CW'(1);
                    stepped     = 1'b1;
                    up_step     = 1'b1;
                end
            end
            if (!up_step && in_down != down_last_reg && el_down > TW'(debounce_reg)) begin
                down_last_next = in_down;
                down_edge_next = in_time;
                if (in_down) begin
                    active_next = active_reg - CW'(1);
                    stepped     = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg      <= mfpc_pkg::CTRL_RESET;
            up_last_reg     <= 1'b1;
            down_last_reg   <= 1'b1;
            up_edge_reg     <= '0;
            down_edge_reg   <= '0;
            toggle_time_reg <= '0;
            toggle_hold_reg <= 1'b0;
            meter_reg       <= 1'b0;
        end else if (s_accept) begin
            active_reg      <= active_next;
            up_last_reg     <= up_last_next;
            down_last_reg   <= down_last_next;
            up_edge_reg     <= up_edge_next;
            down_edge_reg   <= down_edge_next;
            toggle_time_reg <= toggle_time_next;
            toggle_hold_reg <= toggle_hold_next;
            meter_reg       <= meter_next;
        end
    end

    // value store
    logic [mfpc_pkg::STORE_DEPTH-1:0] vld_reg;
    logic [VW-1:0] ram_a;
    logic [VW-1:0] ram_b;
    logic [VW-1:0] scaled;

    mfpc_ram #(
        .WIDTH (VW),
        .DEPTH (mfpc_pkg::STORE_DEPTH)
    ) u_store (
        .aclk    (aclk),
        .we      (s1_fire && s1_wr),
        .waddr   (s1_reg.ctrl_before),
        .wdata   (scaled),
        .re      (s_accept),
        .raddr_a (active_reg),
        .raddr_b (active_next),
        .rdata_a (ram_a),
        .rdata_b (ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (s1_fire && s1_wr) begin
            vld_reg[s1_reg.ctrl_before] <= 1'b1;
        end
    end

    // stage 1: fader path
    mfpc_pkg::stage_t s1_next;
    logic          m_valid_reg;
    logic [SW-1:0] last_fader_reg;
    logic          takeover_reg;
    logic [SW-1:0] diff;
    logic          moved;
    logic          hold_now;
    logic [VW-1:0] stored_a;
    logic [VW-1:0] stored_b;
    logic [mfpc_pkg::LED_W-1:0] leds;
    logic [mfpc_pkg::M_TDATA_W-1:0] m_data_reg, m_data_next;
    logic [mfpc_pkg::M_TUSER_W-1:0] m_user_reg, m_user_next;

    assign s1_fire  = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        s1_next.sample      = in_sample;
        s1_next.ctrl_before = active_reg;
        s1_next.ctrl_after  = active_next;
        s1_next.stepped     = stepped;
        s1_next.meter       = meter_next;
        s1_next.fwd_a       = s1_fire && s1_wr && (s1_reg.ctrl_before == active_reg);
        s1_next.fwd_b       = s1_fire && s1_wr && (s1_reg.ctrl_before == active_next);
        s1_next.fwd_data    = scaled;
        s1_next.vld_a       = vld_reg[active_reg];
        s1_next.vld_b       = vld_reg[active_next];
    end

    always_comb begin
        diff = (s1_reg.sample >= last_fader_reg) ? (s1_reg.sample - last_fader_reg)
                                                 : (last_fader_reg - s1_reg.sample);
        moved  = diff > deadband_reg;
        scaled = VW'(s1_reg.sample >> mfpc_pkg::SCALE_SHIFT);

        stored_a = s1_reg.fwd_a ? s1_reg.fwd_data
                 : s1_reg.vld_a ? ram_a : mfpc_pkg::VALUE_RESET;

        hold_now = takeover_reg;
        if (moved && stored_a == scaled) begin
            hold_now = 1'b0;
        end
        s1_wr = moved && !hold_now;

        if (s1_wr && s1_reg.ctrl_after == s1_reg.ctrl_before) begin
            stored_b = scaled;
        end else if (s1_reg.fwd_b) begin
            stored_b = s1_reg.fwd_data;
        end else if (s1_reg.vld_b) begin
            stored_b = ram_b;
        end else begin
            stored_b = mfpc_pkg::VALUE_RESET;
        end

        leds = s1_reg.meter ? mfpc_pkg::meter_bar(stored_b) : s1_reg.ctrl_after;

        m_data_next = '0;
        m_data_next[mfpc_pkg::M_NUM_LSB +: CW]        = s1_wr ? s1_reg.ctrl_before
                                                              : s1_reg.ctrl_after;
        m_data_next[mfpc_pkg::M_VAL_LSB +: VW]        = s1_wr ? scaled : stored_b;
        m_data_next[mfpc_pkg::M_CHAN_LSB +: mfpc_pkg::CHAN_W] = channel_reg;
        m_data_next[mfpc_pkg::M_LED_LSB +: mfpc_pkg::LED_W]   = leds;

        m_user_next = '0;
        m_user_next[mfpc_pkg::M_SEND_BIT]  = s1_wr;
        m_user_next[mfpc_pkg::M_METER_BIT] = s1_reg.meter;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            m_valid_reg    <= 1'b0;
            last_fader_reg <= '0;
            takeover_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_fire) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire) begin
                m_valid_reg  <= 1'b1;
                takeover_reg <= s1_reg.stepped ? 1'b1 : hold_now;
                if (moved) begin
                    last_fader_reg <= s1_reg.sample;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_reg <= s1_next;
        end
        if (s1_fire) begin
            m_data_reg <= m_data_next;
            m_user_reg <= m_user_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire

// ===== src/mfpc_checker.sv =====
`default_nettype none

module mfpc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              m_tvalid,
    input wire logic                              m_tready,
    input wire logic [mfpc_pkg::M_TDATA_W-1:0]    m_tdata,
    input wire logic [mfpc_pkg::M_TUSER_W-1:0]    m_tuser
);

    logic                         m_send;
    logic                         m_meter;
    logic [mfpc_pkg::LED_W-1:0]   m_led;
    logic [mfpc_pkg::CTRL_W-1:0]  m_num;

    assign m_send  = m_tuser[mfpc_pkg::M_SEND_BIT];
    assign m_meter = m_tuser[mfpc_pkg::M_METER_BIT];
    assign m_led   = m_tdata[mfpc_pkg::M_LED_LSB +: mfpc_pkg::LED_W];
    assign m_num   = m_tdata[mfpc_pkg::M_NUM_LSB +: mfpc_pkg::CTRL_W];

    // no result may follow directly out of reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result presented right after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_binary_leds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_meter && !m_send |-> m_led == m_num)
        else $error("binary display does not show the active controller");

    a_meter_bar: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_meter |->
            (m_led & (m_led + mfpc_pkg::LED_W'(1))) == '0)
        else $error("meter display is not a contiguous bar");

endmodule

bind midi_fader_pickup_controller mfpc_checker u_mfpc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
    import mfpc_pkg::*;

    localparam int DIR_ROWS   = 19;
    localparam int PHASES     = 8;
    localparam int PHASE_LEN  = 190;
    localparam int IDLE_LIMIT = 1000;
    localparam int TAIL       = 8;

    // packed from the top down: time_ms, down, up, sample
    typedef struct packed {
        logic [TIME_W-1:0]   time_ms;
        logic                down;
        logic                up;
        logic [SAMPLE_W-1:0] sample;
    } scan_t;

    // packed from the top down: meter, led, chan, val, num, send
    typedef struct packed {
        logic              meter;
        logic [LED_W-1:0]  led;
        logic [CHAN_W-1:0] chan;
        logic [VAL_W-1:0]  val;
        logic [CTRL_W-1:0] num;
        logic              send;
    } cc_msg_t;

    typedef struct {
        scan_t   item;
        bit      fixed;
        cc_msg_t want;
    } dir_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;
    logic cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = CFG_DEADBAND;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    midi_fader_pickup_controller dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // pickup predictor state
    logic [SAMPLE_W-1:0] deadband;
    logic [DEB_W-1:0]    debounce;
    logic [HOLD_W-1:0]   holdoff;
    logic [CHAN_W-1:0]   channel;
    logic [VAL_W-1:0]    store_val [STORE_DEPTH];
    logic [SAMPLE_W-1:0] fader_last;
    logic [CTRL_W-1:0]   ctrl_now;
    logic                pickup_wait;
    logic                up_level;
    logic                dn_level;
    logic [TIME_W-1:0]   up_stamp;
    logic [TIME_W-1:0]   dn_stamp;
    logic [TIME_W-1:0]   toggle_stamp;
    logic                toggle_lock;
    logic                meter_on;

    // stimulus state
    logic [TIME_W-1:0]   scan_clock = '0;
    logic                hold_up = 1'b0;
    logic                hold_dn = 1'b0;
    logic [SAMPLE_W-1:0] fader_pos = '0;
    bit                  quiet = 1'b0;

    cc_msg_t pending_msgs [$];
    int n_errors = 0;
    int n_items = 0;
    int n_sent = 0;
    int n_toggles = 0;
    int n_steps = 0;
    int idle_cycles = 0;
    int stall_left = 0;

    dir_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{'{32'd0, 1'b0, 1'b0, 10'd0}, 1'b1, '{1'b0, 7'd20, 5'd1, 7'd64, 7'd20, 1'b0}},
        '{'{32'd10, 1'b0, 1'b0, 10'd1023}, 1'b1, '{1'b0, 7'd20, 5'd1, 7'd127, 7'd20, 1'b1}},
        '{'{32'd50, 1'b0, 1'b0, 10'd0}, 1'b1, '{1'b0, 7'd20, 5'd1, 7'd0, 7'd20, 1'b1}},
        '{'{32'd100, 1'b0, 1'b1, 10'd0}, 1'b1, '{1'b0, 7'd21, 5'd1, 7'd64, 7'd21, 1'b0}},
        '{'{32'd110, 1'b0, 1'b0, 10'd0}, 1'b0, '0},
        '{'{32'd200, 1'b0, 1'b0, 10'd0}, 1'b0, '0},
        '{'{32'd300, 1'b1, 1'b0, 10'd0}, 1'b0, '0},
        '{'{32'd400, 1'b0, 1'b0, 10'd0}, 1'b0, '0},
        '{'{32'd410, 1'b0, 1'b0, 10'd512}, 1'b0, '0},
        '{'{32'd420, 1'b0, 1'b0, 10'd7}, 1'b0, '0},
        '{'{32'd1000, 1'b1, 1'b1, 10'd7}, 1'b0, '0},
        '{'{32'd1100, 1'b1, 1'b1, 10'd7}, 1'b0, '0},
        '{'{32'd1200, 1'b0, 1'b0, 10'd7}, 1'b0, '0},
        '{'{32'd1600, 1'b1, 1'b1, 10'd7}, 1'b0, '0},
        '{'{32'd1700, 1'b0, 1'b0, 10'd300}, 1'b0, '0},
        '{'{32'd1800, 1'b1, 1'b1, 10'd300}, 1'b0, '0},
        '{'{32'hFFFF_FFF0, 1'b0, 1'b0, 10'd1023}, 1'b0, '0},
        '{'{32'h0000_0010, 1'b0, 1'b1, 10'd1023}, 1'b0, '0},
        '{'{32'h0000_0100, 1'b0, 1'b0, 10'd0}, 1'b0, '0}
    };

    function automatic void reset_pickup();
        deadband = DEADBAND_RESET;
        debounce = DEBOUNCE_RESET;
        holdoff = HOLDOFF_RESET;
        channel = CHANNEL_RESET;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            store_val[i] = VALUE_RESET;
        end
        fader_last = '0;
        ctrl_now = CTRL_RESET;
        pickup_wait = 1'b0;
        up_level = 1'b1;
        dn_level = 1'b1;
        up_stamp = '0;
        dn_stamp = '0;
        toggle_stamp = '0;
        toggle_lock = 1'b0;
        meter_on = 1'b0;
    endfunction

    function automatic cc_msg_t scan_pass(input scan_t p);
        logic [SAMPLE_W-1:0] delta;
        logic [VAL_W-1:0]    scaled;
        logic [VAL_W-1:0]    stored;
        logic [TIME_W-1:0]   elapsed;
        cc_msg_t             r;
        bit                  done;
        r = '0;
        done = 1'b0;
        delta = (p.sample >= fader_last) ? p.sample - fader_last : fader_last - p.sample;
        if (delta > deadband) begin
            fader_last = p.sample;
            scaled = VAL_W'(p.sample >> SCALE_SHIFT);
            if (store_val[ctrl_now] == scaled) pickup_wait = 1'b0;
            if (!pickup_wait) begin
                store_val[ctrl_now] = scaled;
                r.send = 1'b1;
                r.num = ctrl_now;
                r.val = scaled;
                n_sent++;
            end
        end

        if (p.up && p.down) begin
            if (!toggle_lock) begin
                toggle_lock = 1'b1;
                toggle_stamp = p.time_ms;
                meter_on = !meter_on;
                n_toggles++;
                done = 1'b1;
            end
        end else begin
            elapsed = p.time_ms - toggle_stamp;
            if (elapsed > TIME_W'(holdoff)) toggle_lock = 1'b0;
        end

        elapsed = p.time_ms - up_stamp;
        if (!done && p.up != up_level && elapsed > TIME_W'(debounce)) begin
            up_level = p.up;
            up_stamp = p.time_ms;
            if (p.up) begin
                ctrl_now = ctrl_now + 1'b1;
                pickup_wait = 1'b1;
                n_steps++;
                done = 1'b1;
            end
        end

        elapsed = p.time_ms - dn_stamp;
        if (!done && p.down != dn_level && elapsed > TIME_W'(debounce)) begin
            dn_level = p.down;
            dn_stamp = p.time_ms;
            if (p.down) begin
                ctrl_now = ctrl_now - 1'b1;
                pickup_wait = 1'b1;
                n_steps++;
            end
        end

        stored = store_val[ctrl_now];
        if (!r.send) begin
            r.num = ctrl_now;
            r.val = stored;
        end
        r.chan = channel;
        r.meter = meter_on;
        if (meter_on) begin
            for (int i = 0; i < LED_W; i++) begin
                r.led[i] = (int'(stored) > i * METER_STEP);
            end
        end else begin
            r.led = ctrl_now;
        end
        return r;
    endfunction

    function automatic scan_t next_scan();
        scan_t p;
        int    span;
        int    pos;
        case ($urandom_range(0, 19))
            0: scan_clock = $urandom;
            1, 2, 3: scan_clock = scan_clock + $urandom_range(0, 5);
            4: scan_clock = scan_clock + $urandom_range(400, 70000);
            default: scan_clock = scan_clock + $urandom_range(0, 80);
        endcase
        if ($urandom_range(0, 5) == 0) begin
            {hold_up, hold_dn} = 2'($urandom_range(0, 3));
        end
        case ($urandom_range(0, 9))
            0: fader_pos = SAMPLE_W'($urandom_range(0, 1023));
            1, 2: fader_pos = {store_val[ctrl_now], 3'($urandom_range(0, 7))};
            default: begin
                span = int'(deadband) + 8;
                pos = int'(fader_pos) + int'($urandom_range(0, 2 * span)) - span;
                if (pos < 0) pos = 0;
                if (pos > 1023) pos = 1023;
                fader_pos = SAMPLE_W'(pos);
            end
        endcase
        p.time_ms = scan_clock;
        p.up = hold_up;
        p.down = hold_dn;
        p.sample = fader_pos;
        return p;
    endfunction

    task automatic send_scan(input scan_t p, input bit fixed, input cc_msg_t want);
        cc_msg_t pred;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= S_TDATA_W'(p);
        do @(posedge aclk); while (!s_tready);
        pred = scan_pass(p);
        pending_msgs.push_back(fixed ? want : pred);
        n_items++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_msgs.size() != 0) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        case (idx)
            CFG_DEADBAND: deadband = data[SAMPLE_W-1:0];
            CFG_DEBOUNCE: debounce = data[DEB_W-1:0];
            CFG_HOLDOFF:  holdoff = data[HOLD_W-1:0];
            CFG_CHANNEL:  channel = data[CHAN_W-1:0];
        endcase
    endtask

    task automatic apply_setting(input int unsigned db, input int unsigned deb,
                                 input int unsigned hold, input int unsigned ch);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        write_reg(CFG_DEADBAND, (junk & ~16'h03FF) | CFG_DATA_W'(db));
        write_reg(CFG_DEBOUNCE, (junk & ~16'h00FF) | CFG_DATA_W'(deb));
        write_reg(CFG_HOLDOFF, CFG_DATA_W'(hold));
        write_reg(CFG_CHANNEL, (junk & ~16'h001F) | CFG_DATA_W'(ch));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            n_errors++;
            if (n_errors <= 30) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    always @(posedge aclk) begin
        cc_msg_t want;
        cc_msg_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[M_METER_BIT], m_tdata[M_USED_W-1:0], m_tuser[M_SEND_BIT]};
            if (pending_msgs.size() == 0) begin
                n_errors++;
                $display("%0t: unexpected result item, expected none, actual %h %h", $time,
                         m_tuser, m_tdata);
            end else begin
                want = pending_msgs.pop_front();
                check_field("send_change", want.send, got.send);
                check_field("controller_number", want.num, got.num);
                check_field("controller_value", want.val, got.val);
                check_field("channel_out", want.chan, got.chan);
                check_field("led_pattern", want.led, got.led);
                check_field("display_is_meter", want.meter, got.meter);
                check_field("tdata padding", 0, m_tdata[M_TDATA_W-1:M_USED_W]);
            end
        end
    end

    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no item moved for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin
        reset_pickup();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_scan(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
        end
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: apply_setting(0, 0, 0, 16);
                1: apply_setting(1023, 255, 65535, 0);
                2: apply_setting(3, 5, 40, 31);
                3: apply_setting(8, 30, 500, 1);
                PHASES - 1: apply_setting($urandom_range(0, 40), $urandom_range(0, 60),
                                          $urandom_range(0, 1000), $urandom_range(0, 31));
                default: apply_setting($urandom_range(0, 40), $urandom_range(0, 60),
                                       $urandom_range(0, 1000), $urandom_range(1, 16));
            endcase
            quiet = (ph == PHASES - 1) || ($urandom_range(0, 3) == 0);
            for (int n = 0; n < PHASE_LEN; n++) begin
                if ($urandom_range(0, 99) == 0) drain();
                send_scan(next_scan(), 1'b0, '0);
            end
            drain();
        end

        $display("Ran %0d scan passes over %0d register settings plus reset defaults.",
                 n_items, PHASES);
        $display("Saw %0d control changes, %0d controller steps and %0d display toggles.",
                 n_sent, n_steps, n_toggles);
        if (n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
